/* hw/rtl/spa_pkg.sv */
// Shared constants and transaction types for the sparse polynomial add unit.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int MAX_TERMS = 16;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_MERGE       = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] coef;
    logic [9:0]         expon;
  } in_t;

  typedef struct packed {
    logic signed [16:0] sum_coef;
    logic [9:0]         sum_expon;
    logic               term_valid;
    logic               last;
    logic               truncated;
  } out_t;

  // One stored term as kept in a term store.
  typedef struct packed {
    logic signed [15:0] coef;
    logic [9:0]         expon;
  } term_t;

  localparam int TERM_W = $bits(term_t);

endpackage

/* hw/rtl/spa_term_ram.sv */
// Single write port, single registered read port term store.
`timescale 1ns / 1ps

module spa_term_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 26,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/sparse_polynomial_add_unit.sv */
// Top level of the sparse polynomial add unit: load control, merge sequencer, output register.
`timescale 1ns / 1ps
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) carries one command per
//    transaction: load a term into the first or second store, or merge.
//  - Loads produce nothing. Terms beyond MAX_TERMS per
//    store are dropped and the next merge reports truncated on every item.
//  - A merge stalls the input channel until its final item is in the output
//    register. First head reads issue at the accepting edge, then one head
//    comparison per cycle while the output is not stalled, each consuming one or
//    two stored terms, then a closing step that places the final item. Each
//    store is a registered-read RAM.
//  - An emitted term is held in a register so the last flag can be placed even when
//    the final pair cancels; an all-cancelled or empty sum gives one item with
//    term_valid low.
//  - Output channel (out_valid_o / out_stall_i / out_data_o) is a register; while
//    an item is valid and out_stall_i is high the merge freezes and the item holds.
//  - Reset clears counts, the overflow flag and the sequencer; store contents
//    stay undefined and are only read below the counts.
//  - Operation code 3 is accepted and ignored.

module sparse_polynomial_add_unit
  import spa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,

  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,

  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic             ovf_q, ovf_d;
  out_t             hold_q, hold_d;
  logic             hold_valid_q, hold_valid_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic         in_fire, we_a, we_b;
  logic [TERM_W-1:0] rdata_a, rdata_b;
  term_t        head_a, head_b;
  term_t        wterm;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wterm.coef  = in_data_i.coef;
  assign wterm.expon = in_data_i.expon;

  assign we_a = in_fire && (in_data_i.operation == OP_LOAD_FIRST)
                && (cnt_a_q < CNT_W'(MAX_TERMS));
  assign we_b = in_fire && (in_data_i.operation == OP_LOAD_SECOND)
                && (cnt_b_q < CNT_W'(MAX_TERMS));

  // Read address follows the next head index so the registered read data lines up with the head index.
  spa_term_ram #(.DEPTH(MAX_TERMS), .WIDTH(TERM_W)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IDX_W-1:0]),
    .wdata_i (wterm),
    .raddr_i (idx_a_d[IDX_W-1:0]),
    .rdata_o (rdata_a)
  );

  spa_term_ram #(.DEPTH(MAX_TERMS), .WIDTH(TERM_W)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IDX_W-1:0]),
    .wdata_i (wterm),
    .raddr_i (idx_b_d[IDX_W-1:0]),
    .rdata_o (rdata_b)
  );

  assign head_a = term_t'(rdata_a);
  assign head_b = term_t'(rdata_b);

  // Head comparison
  logic               a_has, b_has, done;
  logic               cand_emit, inc_a, inc_b;
  logic signed [16:0] coef_a, coef_b, cand_coef;
  logic [9:0]         cand_expon;
  logic               out_free, advance;

  assign a_has  = idx_a_q < cnt_a_q;
  assign b_has  = idx_b_q < cnt_b_q;
  assign done   = !a_has && !b_has;
  assign coef_a = 17'(head_a.coef);
  assign coef_b = 17'(head_b.coef);

  always_comb begin
    cand_emit  = 1'b1;
    inc_a      = 1'b0;
    inc_b      = 1'b0;
    cand_coef  = coef_a;
    cand_expon = head_a.expon;
    if (a_has && b_has) begin
      if (head_a.expon < head_b.expon) begin
        cand_coef  = coef_b;
        cand_expon = head_b.expon;
        inc_b      = 1'b1;
      end else if (head_a.expon > head_b.expon) begin
        inc_a = 1'b1;
      end else begin
        cand_coef = coef_a + coef_b;
        cand_emit = (cand_coef != 17'sd0);
        inc_a     = 1'b1;
        inc_b     = 1'b1;
      end
    end else if (a_has) begin
      inc_a = 1'b1;
    end else begin
      cand_coef  = coef_b;
      cand_expon = head_b.expon;
      inc_b      = b_has;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = (state_q == ST_MERGE) && out_free;

  always_comb begin
    state_d      = state_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    idx_a_d      = idx_a_q;
    idx_b_d      = idx_b_q;
    ovf_d        = ovf_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (in_fire) begin
      case (in_data_i.operation)
        OP_LOAD_FIRST: begin
          if (we_a) cnt_a_d = cnt_a_q + CNT_W'(1);
          else      ovf_d   = 1'b1;
        end
        OP_LOAD_SECOND: begin
          if (we_b) cnt_b_d = cnt_b_q + CNT_W'(1);
          else      ovf_d   = 1'b1;
        end
        OP_MERGE: begin
          state_d = ST_MERGE;
          idx_a_d = '0;
          idx_b_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (advance) begin
      if (!done) begin
        idx_a_d = idx_a_q + CNT_W'(inc_a);
        idx_b_d = idx_b_q + CNT_W'(inc_b);
        if (cand_emit) begin
          if (hold_valid_q) begin
            out_d           = hold_q;
            out_d.last      = 1'b0;
            out_d.truncated = ovf_q;
            out_valid_d     = 1'b1;
          end
          hold_d.sum_coef   = cand_coef;
          hold_d.sum_expon  = cand_expon;
          hold_d.term_valid = 1'b1;
          hold_d.last       = 1'b0;
          hold_d.truncated  = 1'b0;
          hold_valid_d      = 1'b1;
        end
      end else begin
        if (hold_valid_q) begin
          out_d = hold_q;
        end else begin
          out_d.sum_coef   = '0;
          out_d.sum_expon  = '0;
          out_d.term_valid = 1'b0;
        end
        out_d.last      = 1'b1;
        out_d.truncated = ovf_q;
        out_valid_d     = 1'b1;
        hold_valid_d    = 1'b0;
        state_d         = ST_IDLE;
        cnt_a_d         = '0;
        cnt_b_d         = '0;
        ovf_d           = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      idx_a_q      <= '0;
      idx_b_q      <= '0;
      ovf_q        <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      idx_a_q      <= idx_a_d;
      idx_b_q      <= idx_b_d;
      ovf_q        <= ovf_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  // Checks
  a_idx_a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (idx_a_q <= cnt_a_q))
    else $error("first head index ran past its count");

  a_idx_b_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (idx_b_q <= cnt_b_q))
    else $error("second head index ran past its count");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CNT_W'(MAX_TERMS)) && (cnt_b_q <= CNT_W'(MAX_TERMS)))
    else $error("term count above capacity");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_valid_q)
    else $error("held term left behind after merge");

  a_merge_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.operation == OP_MERGE) |=> (in_stall_o && idx_a_q == '0))
    else $error("merge did not start");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && done) |=> (state_q == ST_IDLE && out_valid_q && out_q.last))
    else $error("merge closed without a last item");

endmodule
